### rtl/core/ekmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ekmf_pkg;

  // Node and field widths, fixed by the request format
  localparam int NODE_W    = 6;
  localparam int MAX_NODES = 64;
  localparam int CAP_WIDTH = 16;
  localparam int FLOW_W    = 24;
  localparam int NCNT_W    = 7;
  localparam int STEP_W    = 7;
  localparam int QPTR_W    = 7;

  localparam int DEF_MAX_EDGE_ENTRIES = 256;

  // Command codes
  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_NODE = 2'd2;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = NCNT_W'(64);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_REV,
    S_BFS_INIT,
    S_POP,
    S_CUR,
    S_SCAN,
    S_P1_PAR,
    S_P1_EDG,
    S_P1_UPD,
    S_P2_PAR,
    S_P2_EDG,
    S_P2_FWD,
    S_P2_REV,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_ADD_FWD,
    OP_ADD_REV,
    OP_BFS_INIT,
    OP_POP,
    OP_CUR,
    OP_SCAN,
    OP_WALK_START,
    OP_WALK2_START,
    OP_P_PAR,
    OP_P_EDG,
    OP_P1_UPD,
    OP_P2_FWD,
    OP_P2_REV,
    OP_TOTAL,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] status;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bad_node;
    logic       full;
    logic       q_nonempty;
    logic       sink_reached;
    logic       scan_done;
    logic       walk_end;
    logic       slot_free;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/ekmf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ekmf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ekmf_pkg::stat_t stat_i,
  output ekmf_pkg::ctrl_t      ctrl_o
);

  ekmf_pkg::state_e state_q, state_d;
  logic [1:0]       status_q, status_d;

  // Hold state and result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ekmf_pkg::S_IDLE;
      status_q <= ekmf_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // Sequence one request through decode, then an edge add or search and augment
  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    in_stall_o    = 1'b1;
    ctrl_o.op     = ekmf_pkg::OP_NONE;
    ctrl_o.status = status_q;
    case (state_q)
      ekmf_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.op = ekmf_pkg::OP_LATCH;
          state_d   = ekmf_pkg::S_DECODE;
        end
      end
      ekmf_pkg::S_DECODE: begin
        status_d = ekmf_pkg::ST_OK;
        state_d  = ekmf_pkg::S_DONE;
        case (stat_i.cmd)
          ekmf_pkg::CMD_ADD: begin
            if (stat_i.bad_node) begin
              status_d = ekmf_pkg::ST_BAD_NODE;
            end else if (stat_i.full) begin
              status_d = ekmf_pkg::ST_FULL;
            end else begin
              ctrl_o.op = ekmf_pkg::OP_ADD_FWD;
              state_d   = ekmf_pkg::S_ADD_REV;
            end
          end
          ekmf_pkg::CMD_COMPUTE: begin
            if (stat_i.bad_node) begin
              status_d = ekmf_pkg::ST_BAD_NODE;
            end else begin
              state_d = ekmf_pkg::S_BFS_INIT;
            end
          end
          ekmf_pkg::CMD_CLEAR: begin
            ctrl_o.op = ekmf_pkg::OP_CLEAR;
          end
          default: begin
          end
        endcase
      end
      ekmf_pkg::S_ADD_REV: begin
        ctrl_o.op = ekmf_pkg::OP_ADD_REV;
        state_d   = ekmf_pkg::S_DONE;
      end
      ekmf_pkg::S_BFS_INIT: begin
        ctrl_o.op = ekmf_pkg::OP_BFS_INIT;
        state_d   = ekmf_pkg::S_POP;
      end
      ekmf_pkg::S_POP: begin
        if (stat_i.sink_reached) begin
          ctrl_o.op = ekmf_pkg::OP_WALK_START;
          state_d   = ekmf_pkg::S_P1_PAR;
        end else if (stat_i.q_nonempty) begin
          ctrl_o.op = ekmf_pkg::OP_POP;
          state_d   = ekmf_pkg::S_CUR;
        end else begin
          state_d = ekmf_pkg::S_DONE;
        end
      end
      ekmf_pkg::S_CUR: begin
        ctrl_o.op = ekmf_pkg::OP_CUR;
        state_d   = ekmf_pkg::S_SCAN;
      end
      ekmf_pkg::S_SCAN: begin
        ctrl_o.op = ekmf_pkg::OP_SCAN;
        if (stat_i.scan_done) begin
          state_d = ekmf_pkg::S_POP;
        end
      end
      // First walk: find the bottleneck
      ekmf_pkg::S_P1_PAR: begin
        if (stat_i.walk_end) begin
          ctrl_o.op = ekmf_pkg::OP_WALK2_START;
          state_d   = ekmf_pkg::S_P2_PAR;
        end else begin
          ctrl_o.op = ekmf_pkg::OP_P_PAR;
          state_d   = ekmf_pkg::S_P1_EDG;
        end
      end
      ekmf_pkg::S_P1_EDG: begin
        ctrl_o.op = ekmf_pkg::OP_P_EDG;
        state_d   = ekmf_pkg::S_P1_UPD;
      end
      ekmf_pkg::S_P1_UPD: begin
        ctrl_o.op = ekmf_pkg::OP_P1_UPD;
        state_d   = ekmf_pkg::S_P1_PAR;
      end
      // Second walk: push the bottleneck along the path
      ekmf_pkg::S_P2_PAR: begin
        if (stat_i.walk_end) begin
          ctrl_o.op = ekmf_pkg::OP_TOTAL;
          state_d   = ekmf_pkg::S_BFS_INIT;
        end else begin
          ctrl_o.op = ekmf_pkg::OP_P_PAR;
          state_d   = ekmf_pkg::S_P2_EDG;
        end
      end
      ekmf_pkg::S_P2_EDG: begin
        ctrl_o.op = ekmf_pkg::OP_P_EDG;
        state_d   = ekmf_pkg::S_P2_FWD;
      end
      ekmf_pkg::S_P2_FWD: begin
        ctrl_o.op = ekmf_pkg::OP_P2_FWD;
        state_d   = ekmf_pkg::S_P2_REV;
      end
      ekmf_pkg::S_P2_REV: begin
        ctrl_o.op = ekmf_pkg::OP_P2_REV;
        state_d   = ekmf_pkg::S_P2_PAR;
      end
      ekmf_pkg::S_DONE: begin
        if (stat_i.slot_free) begin
          ctrl_o.op = ekmf_pkg::OP_RESULT;
          state_d   = ekmf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ekmf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ekmf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ekmf_dp #(
  parameter int MAX_EDGE_ENTRIES = ekmf_pkg::DEF_MAX_EDGE_ENTRIES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ekmf_pkg::ctrl_t               ctrl_i,
  output ekmf_pkg::stat_t                    stat_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [ekmf_pkg::NODE_W-1:0]   from_node_i,
  input  wire logic [ekmf_pkg::NODE_W-1:0]   to_node_i,
  input  wire logic [15:0]                   capacity_i,
  input  wire logic                          cfg_write_i,
  input  wire logic [ekmf_pkg::NCNT_W-1:0]   cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ekmf_pkg::FLOW_W-1:0]        max_flow_o,
  output logic [1:0]                         status_o
);

  localparam int EW  = (MAX_EDGE_ENTRIES > 2) ? $clog2(MAX_EDGE_ENTRIES) : 1;
  localparam int ETW = $clog2(MAX_EDGE_ENTRIES + 1);
  localparam int NW  = ekmf_pkg::NODE_W;
  localparam int CW  = ekmf_pkg::CAP_WIDTH;
  localparam int FW  = ekmf_pkg::FLOW_W;

  typedef struct packed {
    logic [NW-1:0] src;
    logic [NW-1:0] dst;
    logic [CW-1:0] res;
  } edge_t;

  // Edge table keeps residual capacity only; a pair's residuals sum to its capacity
  edge_t         edge_mem [MAX_EDGE_ENTRIES];
  logic [EW-1:0] par_mem  [ekmf_pkg::MAX_NODES];
  logic [NW-1:0] q_mem    [ekmf_pkg::MAX_NODES];

  logic [1:0]                      cmd_q;
  logic [NW-1:0]                   a_q, b_q;
  logic [CW-1:0]                   cap_q;
  logic [ekmf_pkg::NCNT_W-1:0]     ncnt_q;
  logic [ETW-1:0]                  etot_q;
  logic [ETW-1:0]                  scan_q;
  logic                            pend_q;
  logic [EW-1:0]                   chk_idx_q;
  logic [NW-1:0]                   cur_q;
  logic [ekmf_pkg::QPTR_W-1:0]     head_q, tail_q;
  logic [ekmf_pkg::MAX_NODES-1:0]  reached_q;
  logic [NW-1:0]                   v_q;
  logic [ekmf_pkg::STEP_W-1:0]     steps_q;
  logic [EW-1:0]                   e_q;
  logic [CW-1:0]                   bneck_q;
  logic [FW-1:0]                   total_q;
  edge_t                           edge_rd_q;
  logic [EW-1:0]                   par_rd_q;
  logic [NW-1:0]                   q_rd_q;
  logic                            out_valid_q;
  logic [FW-1:0]                   max_flow_q;
  logic [1:0]                      status_q;

  logic          e_we, e_re, p_we, p_re, q_we, q_re;
  logic [EW-1:0] e_waddr, e_raddr;
  edge_t         e_wdata;
  logic [NW-1:0] p_waddr, q_waddr;
  logic [EW-1:0] p_wdata;
  logic [NW-1:0] q_wdata;
  logic          hit;
  logic [ETW:0]  etot_plus2;
  logic [FW:0]   total_sum;

  // Scan candidate: leaves the current node, reaches a new node, has residual
  assign hit = pend_q && (edge_rd_q.src == cur_q) && !reached_q[edge_rd_q.dst] &&
               (edge_rd_q.dst != a_q) && (edge_rd_q.res != '0);

  assign etot_plus2 = {1'b0, etot_q} + (ETW+1)'(2);
  assign total_sum  = {1'b0, total_q} + (FW+1)'(bneck_q);

  // Status toward the controller
  always_comb begin
    stat_o.cmd          = cmd_q;
    stat_o.bad_node     = !(({1'b0, a_q} < ncnt_q) && ({1'b0, b_q} < ncnt_q));
    stat_o.full         = etot_plus2 > (ETW+1)'(MAX_EDGE_ENTRIES);
    stat_o.q_nonempty   = head_q < tail_q;
    stat_o.sink_reached = reached_q[b_q];
    stat_o.scan_done    = !pend_q && (scan_q >= etot_q);
    stat_o.walk_end     = (v_q == a_q) || (steps_q > ekmf_pkg::STEP_W'(ekmf_pkg::MAX_NODES));
    stat_o.slot_free    = !out_valid_q || !out_stall_i;
  end

  // Select memory ports for the current step
  always_comb begin
    e_we    = 1'b0;
    e_waddr = etot_q[EW-1:0];
    e_wdata = edge_rd_q;
    e_re    = 1'b0;
    e_raddr = scan_q[EW-1:0];
    p_we    = 1'b0;
    p_waddr = edge_rd_q.dst;
    p_wdata = chk_idx_q;
    p_re    = 1'b0;
    q_we    = 1'b0;
    q_waddr = tail_q[NW-1:0];
    q_wdata = edge_rd_q.dst;
    q_re    = 1'b0;
    case (ctrl_i.op)
      ekmf_pkg::OP_ADD_FWD: begin
        e_we    = 1'b1;
        e_wdata = '{src: a_q, dst: b_q, res: cap_q};
      end
      ekmf_pkg::OP_ADD_REV: begin
        e_we    = 1'b1;
        e_waddr = etot_q[EW-1:0] + EW'(1);
        e_wdata = '{src: b_q, dst: a_q, res: '0};
      end
      ekmf_pkg::OP_BFS_INIT: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = a_q;
      end
      ekmf_pkg::OP_POP: begin
        q_re = 1'b1;
      end
      ekmf_pkg::OP_SCAN: begin
        e_re = scan_q < etot_q;
        p_we = hit;
        q_we = hit && (tail_q < ekmf_pkg::QPTR_W'(ekmf_pkg::MAX_NODES));
      end
      ekmf_pkg::OP_P_PAR: begin
        p_re = 1'b1;
      end
      ekmf_pkg::OP_P_EDG: begin
        e_re    = 1'b1;
        e_raddr = par_rd_q;
      end
      ekmf_pkg::OP_P2_FWD: begin
        e_we        = 1'b1;
        e_waddr     = e_q;
        e_wdata.res = edge_rd_q.res - bneck_q;
        e_re        = 1'b1;
        e_raddr     = e_q ^ EW'(1);
      end
      ekmf_pkg::OP_P2_REV: begin
        e_we        = 1'b1;
        e_waddr     = e_q ^ EW'(1);
        e_wdata.res = edge_rd_q.res + bneck_q;
      end
      default: begin
      end
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk_i) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    if (e_re) begin
      edge_rd_q <= edge_mem[e_raddr];
    end
    if (p_we) begin
      par_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      par_rd_q <= par_mem[v_q];
    end
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= q_mem[head_q[NW-1:0]];
    end
  end

  // Request payload and path registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      ekmf_pkg::OP_LATCH: begin
        cmd_q   <= cmd_i;
        a_q     <= from_node_i;
        b_q     <= to_node_i;
        cap_q   <= capacity_i[CW-1:0];
        total_q <= '0;
      end
      ekmf_pkg::OP_CUR: begin
        cur_q <= q_rd_q;
      end
      ekmf_pkg::OP_SCAN: begin
        chk_idx_q <= scan_q[EW-1:0];
      end
      ekmf_pkg::OP_WALK_START: begin
        v_q     <= b_q;
        bneck_q <= '1;
      end
      ekmf_pkg::OP_WALK2_START: begin
        v_q <= b_q;
      end
      ekmf_pkg::OP_P_EDG: begin
        e_q <= par_rd_q;
      end
      ekmf_pkg::OP_P1_UPD: begin
        if (edge_rd_q.res < bneck_q) begin
          bneck_q <= edge_rd_q.res;
        end
        v_q <= edge_rd_q.src;
      end
      ekmf_pkg::OP_P2_FWD: begin
        v_q <= edge_rd_q.src;
      end
      ekmf_pkg::OP_TOTAL: begin
        total_q <= total_sum[FW] ? '1 : total_sum[FW-1:0];
      end
      ekmf_pkg::OP_RESULT: begin
        max_flow_q <= total_q;
        status_q   <= ctrl_i.status;
      end
      default: begin
      end
    endcase
  end

  // Control registers: counts, pointers, search marks, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q      <= ekmf_pkg::NODE_COUNT_RESET;
      etot_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      reached_q   <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        ncnt_q <= cfg_data_i;
      end
      if (ctrl_i.op == ekmf_pkg::OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (ctrl_i.op)
        ekmf_pkg::OP_CLEAR: begin
          etot_q <= '0;
        end
        ekmf_pkg::OP_ADD_REV: begin
          etot_q <= etot_plus2[ETW-1:0];
        end
        ekmf_pkg::OP_BFS_INIT: begin
          reached_q <= '0;
          head_q    <= '0;
          tail_q    <= ekmf_pkg::QPTR_W'(1);
        end
        ekmf_pkg::OP_POP: begin
          head_q <= head_q + ekmf_pkg::QPTR_W'(1);
        end
        ekmf_pkg::OP_CUR: begin
          scan_q <= '0;
          pend_q <= 1'b0;
        end
        ekmf_pkg::OP_SCAN: begin
          pend_q <= e_re;
          if (e_re) begin
            scan_q <= scan_q + ETW'(1);
          end
          if (hit) begin
            reached_q[edge_rd_q.dst] <= 1'b1;
          end
          if (q_we) begin
            tail_q <= tail_q + ekmf_pkg::QPTR_W'(1);
          end
        end
        ekmf_pkg::OP_WALK_START,
        ekmf_pkg::OP_WALK2_START: begin
          steps_q <= '0;
        end
        ekmf_pkg::OP_P1_UPD,
        ekmf_pkg::OP_P2_REV: begin
          steps_q <= steps_q + ekmf_pkg::STEP_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_flow_o  = max_flow_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

### rtl/core/edmonds_karp_max_flow.sv
// Channel   Direction  Handshake            Payload
// in        in         in_valid_i/in_stall_o  cmd_i from_node_i to_node_i capacity_i
// out       out        out_valid_o/out_stall_i max_flow_o status_o
// cfg       in         cfg_valid_i/cfg_ready_o cfg_data_i (node_count)
//
// One request at a time. An add writes its forward edge in decode and its reverse
// edge in S_ADD_REV; clear, rejected and unused requests go from decode to S_DONE.
// A compute repeats rounds: each dequeued node scans the whole edge table through
// the single read port of the edge memory; each path edge passes S_P1_PAR, S_P1_EDG,
// S_P1_UPD for the bottleneck and S_P2_PAR to S_P2_REV to update residuals.
// Reset clears the edge count and sets node_count to 64; no clearing pass.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module edmonds_karp_max_flow #(
  parameter int MAX_EDGE_ENTRIES = ekmf_pkg::DEF_MAX_EDGE_ENTRIES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [ekmf_pkg::NODE_W-1:0] from_node_i,
  input  wire logic [ekmf_pkg::NODE_W-1:0] to_node_i,
  input  wire logic [15:0]                 capacity_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ekmf_pkg::FLOW_W-1:0]      max_flow_o,
  output logic [1:0]                       status_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ekmf_pkg::NCNT_W-1:0] cfg_data_i
);

  ekmf_pkg::ctrl_t ctrl;
  ekmf_pkg::stat_t stat;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  ekmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ekmf_dp #(
    .MAX_EDGE_ENTRIES (MAX_EDGE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cmd_i       (cmd_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .capacity_i  (capacity_i),
    .cfg_write_i (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .max_flow_o  (max_flow_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

### rtl/core/ekmf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ekmf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [ekmf_pkg::FLOW_W-1:0] max_flow_o,
  input wire logic [1:0]                  status_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(max_flow_o) && $stable(status_o))
    else $error("stalled result changed");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ekmf_pkg::ST_OK || status_o == ekmf_pkg::ST_FULL ||
                     status_o == ekmf_pkg::ST_BAD_NODE))
    else $error("undefined status code");

  // Rejected requests carry no flow
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ekmf_pkg::ST_OK |-> max_flow_o == '0)
    else $error("rejected request returned flow");

  // One request in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

endmodule

bind edmonds_karp_max_flow ekmf_checker u_ekmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .max_flow_o  (max_flow_o),
  .status_o    (status_o)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int EDGES     = ekmf_pkg::DEF_MAX_EDGE_ENTRIES;
  localparam int NODES     = ekmf_pkg::MAX_NODES;
  localparam int FW        = ekmf_pkg::FLOW_W;
  localparam int CYCLE_CAP = 3000000;
  localparam int DRAIN_GAP = 40;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] cap;
  } request_t;

  typedef struct {
    logic [FW-1:0] flow;
    logic [1:0]    status;
  } answer_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] cmd_i;
  logic [ekmf_pkg::NODE_W-1:0] from_node_i, to_node_i;
  logic [15:0] capacity_i;
  logic out_valid_o, out_stall_i;
  logic [FW-1:0] max_flow_o;
  logic [1:0] status_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [ekmf_pkg::NCNT_W-1:0] cfg_data_i;

  edmonds_karp_max_flow DUT (.*);

  // Graph mirror used to predict each result
  int unsigned nodes_used;
  int unsigned g_src [EDGES];
  int unsigned g_dst [EDGES];
  longint      g_cap [EDGES];
  longint      g_flw [EDGES];
  int unsigned g_cnt;
  int unsigned via_edge [NODES];

  request_t pending_q[$];
  answer_t  answer_q[$];
  int errors;
  int unsigned cycles;
  int gap_in, gap_out, hold_cycles;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic bit node_valid(int unsigned n);
    return n < nodes_used && n < NODES;
  endfunction

  // Breadth-first search over residual edges, in table order
  function automatic bit find_path(int unsigned s, int unsigned t);
    int unsigned fifo [NODES];
    bit seen [NODES];
    int unsigned hd, tl, cur;
    hd = 0; tl = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    fifo[tl++] = s;
    while (hd < tl && !seen[t]) begin
      cur = fifo[hd++];
      for (int unsigned e = 0; e < g_cnt; e++) begin
        if (g_src[e] == cur && !seen[g_dst[e]] && g_dst[e] != s &&
            g_cap[e] - g_flw[e] > 0) begin
          seen[g_dst[e]] = 1'b1;
          via_edge[g_dst[e]] = e;
          if (tl < NODES) fifo[tl++] = g_dst[e];
        end
      end
    end
    return seen[t];
  endfunction

  function automatic longint augment_all(int unsigned s, int unsigned t);
    longint total, neck;
    int unsigned v, steps, e;
    total = 0;
    while (find_path(s, t)) begin
      neck = 64'h7fff_ffff_ffff_ffff;
      v = t; steps = 0;
      while (v != s && steps <= NODES) begin
        e = via_edge[v];
        if (g_cap[e] - g_flw[e] < neck) neck = g_cap[e] - g_flw[e];
        v = g_src[e]; steps++;
      end
      v = t; steps = 0;
      while (v != s && steps <= NODES) begin
        e = via_edge[v];
        g_flw[e] += neck;
        g_flw[e ^ 1] -= neck;
        v = g_src[e]; steps++;
      end
      total += neck;
      if (total > 64'hFF_FFFF) total = 64'hFF_FFFF;
    end
    return total;
  endfunction

  // Update the mirror for one accepted request and queue its answer
  function automatic void predict_answer(request_t r);
    answer_t a;
    a.flow = '0;
    a.status = ekmf_pkg::ST_OK;
    if (r.cmd == ekmf_pkg::CMD_ADD || r.cmd == ekmf_pkg::CMD_COMPUTE) begin
      if (!node_valid(r.src) || !node_valid(r.dst)) begin
        a.status = ekmf_pkg::ST_BAD_NODE;
      end else if (r.cmd == ekmf_pkg::CMD_ADD) begin
        if (g_cnt + 2 > EDGES) begin
          a.status = ekmf_pkg::ST_FULL;
        end else begin
          g_src[g_cnt] = r.src; g_dst[g_cnt] = r.dst;
          g_cap[g_cnt] = r.cap; g_flw[g_cnt] = 0;
          g_src[g_cnt+1] = r.dst; g_dst[g_cnt+1] = r.src;
          g_cap[g_cnt+1] = 0; g_flw[g_cnt+1] = 0;
          g_cnt += 2;
        end
      end else begin
        a.flow = FW'(augment_all(r.src, r.dst));
      end
    end else if (r.cmd == ekmf_pkg::CMD_CLEAR) begin
      g_cnt = 0;
    end
    answer_q.push_back(a);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Request driver: hold while stalled, advance on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        predict_answer(request_t'{cmd_i, from_node_i, to_node_i, capacity_i});
      if (!in_valid_i || !in_stall_o) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          request_t r;
          r = pending_q.pop_front();
          cmd_i <= r.cmd; from_node_i <= r.src;
          to_node_i <= r.dst; capacity_i <= r.cap;
          in_valid_i <= 1'b1;
          gap_in <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result monitor: compare against the oldest expected answer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result, status", status_o, 0);
        end else begin
          answer_t a;
          a = answer_q.pop_front();
          if (max_flow_o !== a.flow) report_mismatch("max_flow", max_flow_o, a.flow);
          if (status_o !== a.status) report_mismatch("status", status_o, a.status);
        end
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        gap_out <= pick_gap();
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i)
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] c, int s, int d, int cap);
    pending_q.push_back(request_t'{c, 6'(s), 6'(d), 16'(cap)});
  endtask

  // Wait until every request is sent and answered, sampled between edges
  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || answer_q.size() != 0);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_node_count(int v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= ekmf_pkg::NCNT_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    nodes_used = v;
  endtask

  function automatic int rand_cap();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 0;
    if (p == 1) return 16'hFFFF;
    if (p < 6) return $urandom_range(20, 1);
    return $urandom_range(16'hFFFF);
  endfunction

  initial begin
    int nc, span;
    int node_counts [8];
    node_counts = '{3, 6, 8, 64, 12, 127, 2, 5};
    rst_ni = 1'b0;
    in_valid_i = 1'b0; out_stall_i = 1'b0; cfg_valid_i = 1'b0;
    cmd_i = '0; from_node_i = '0; to_node_i = '0; capacity_i = '0; cfg_data_i = '0;
    errors = 0; cycles = 0; gap_in = 0; gap_out = 0; hold_cycles = 0;
    nodes_used = 64; g_cnt = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, unused command, source equal to sink
    push_req(ekmf_pkg::CMD_ADD, 0, 1, 0);
    push_req(ekmf_pkg::CMD_ADD, 63, 62, 16'hFFFF);
    push_req(ekmf_pkg::CMD_COMPUTE, 0, 0, 0);
    push_req(ekmf_pkg::CMD_COMPUTE, 0, 1, 0);
    push_req(ekmf_pkg::CMD_COMPUTE, 63, 62, 16'hFFFF);
    push_req(2'd3, 63, 63, 16'hFFFF);
    push_req(ekmf_pkg::CMD_CLEAR, 0, 0, 0);
    drain();
    // Directed: bad nodes and a graph whose max flow needs a reverse edge
    write_node_count(5);
    push_req(ekmf_pkg::CMD_ADD, 5, 0, 3);
    push_req(ekmf_pkg::CMD_COMPUTE, 1, 63, 0);
    push_req(ekmf_pkg::CMD_ADD, 0, 1, 10);
    push_req(ekmf_pkg::CMD_ADD, 0, 2, 10);
    push_req(ekmf_pkg::CMD_ADD, 1, 3, 4);
    push_req(ekmf_pkg::CMD_ADD, 2, 3, 8);
    push_req(ekmf_pkg::CMD_ADD, 1, 2, 5);
    push_req(ekmf_pkg::CMD_ADD, 3, 4, 100);
    push_req(ekmf_pkg::CMD_COMPUTE, 0, 4, 0);
    push_req(ekmf_pkg::CMD_COMPUTE, 0, 4, 0);
    push_req(ekmf_pkg::CMD_COMPUTE, 4, 0, 0);
    push_req(ekmf_pkg::CMD_CLEAR, 0, 0, 0);
    drain();
    // Fill the edge table, then overflow it; bad node wins over full
    write_node_count(2);
    for (int i = 0; i < EDGES / 2; i++) push_req(ekmf_pkg::CMD_ADD, 0, 1, 16'hFFFF);
    push_req(ekmf_pkg::CMD_ADD, 1, 0, 1);
    push_req(ekmf_pkg::CMD_ADD, 2, 0, 1);
    push_req(ekmf_pkg::CMD_COMPUTE, 0, 1, 0);
    push_req(ekmf_pkg::CMD_CLEAR, 0, 0, 0);
    drain();
    write_node_count(0);
    push_req(ekmf_pkg::CMD_COMPUTE, 0, 0, 0);
    push_req(ekmf_pkg::CMD_ADD, 0, 1, 1);
    drain();

    // Random phases: edge groups followed by a compute, plus noise
    foreach (node_counts[p]) begin
      nc = node_counts[p];
      span = (nc > 64) ? 64 : nc;
      write_node_count(nc);
      push_req(ekmf_pkg::CMD_CLEAR, 0, 0, 0);
      for (int grp = 0; grp < 19; grp++) begin
        if (grp % 4 == 3) push_req(ekmf_pkg::CMD_CLEAR, 0, 0, 0);
        repeat ($urandom_range(6, 1))
          push_req(ekmf_pkg::CMD_ADD, $urandom_range(span - 1), $urandom_range(span - 1),
                   rand_cap());
        if ($urandom_range(99) < 25)
          push_req(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                   $urandom_range(16'hFFFF));
        push_req(ekmf_pkg::CMD_COMPUTE, $urandom_range(span - 1), $urandom_range(span - 1),
                 rand_cap());
        // Hold the receiver off long enough to back up the input
        if (p == 3 && grp == 5) begin
          wait (pending_q.size() < 4);
          hold_cycles = 400;
        end
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### edmonds_karp_max_flow.f
rtl/core/ekmf_pkg.sv
rtl/core/ekmf_ctrl.sv
rtl/core/ekmf_dp.sv
rtl/core/edmonds_karp_max_flow.sv
rtl/core/ekmf_checker.sv
tb/sv/testbench.sv
